// ===== design/imhq_pkg.sv =====
`timescale 1ns / 1ps
package imhq_pkg;

	localparam int REQ_W   = 3;
	localparam int STAT_W  = 3;
	localparam int SCORE_W = 32;
	localparam int CFG_W   = 7;

	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FIND   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RAISE  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LOWER  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd5;
	localparam logic [REQ_W-1:0] REQ_CROWN  = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LOC,
		S_RDRES,
		S_ADJ,
		S_PRD,
		S_POP,
		S_SU_RD,
		S_SU_CMP,
		S_SD_RD,
		S_SD_CMP,
		S_DONE
	} imhq_state_t;

endpackage

// ===== design/imhq_adjust.sv =====
`timescale 1ns / 1ps
module imhq_adjust (
	input  logic signed [imhq_pkg::SCORE_W-1:0] cur,
	input  logic signed [imhq_pkg::SCORE_W-1:0] delta,
	input  logic                                sub,
	output logic signed [imhq_pkg::SCORE_W-1:0] res
);
	import imhq_pkg::*;

	logic signed [SCORE_W:0] a_w;
	logic signed [SCORE_W:0] d_w;
	logic signed [SCORE_W:0] sum;

	always_comb begin
		a_w = {cur[SCORE_W-1], cur};
		d_w = {delta[SCORE_W-1], delta};
		sum = sub ? (a_w - d_w) : (a_w + d_w);
		// clamp to the signed score range
		if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			res = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			res = sum[SCORE_W-1:0];
		end
	end

endmodule

// ===== design/indexed_min_heap_queue.sv =====
`timescale 1ns / 1ps
// indexed binary min-heap of (id, score) entries with an id-to-slot handle table.
// input stream s_*: one request per transfer (insert, find, pop, raise, lower,
// location, crown). output stream m_*: exactly one result per request, in order.
// cfg_we/cfg_wdata write the capacity limit (reset 64); write it only while idle.
// the heap and the handle table sit in synchronous memories with registered
// reads; every request is worked by a sequencer one at a time.
// find and location read the handle, then the entry; rejected or unknown requests
// go straight from the lookup to the result. insert sifts the new entry up, then
// down; raise and lower adjust the score and sift it the same way. pop removes the
// root, moves the last entry there and sifts it down; crown repeats the pop body
// once per removed entry. the next request is taken in the cycle after the result
// is registered. after reset the handle table is cleared one entry a cycle, all
// MAX_ENTRIES + 1 entries, with s_tready low; the heap starts empty.
// a finished result waits in the output register; the next request is taken
// meanwhile, and its result holds until the receiver takes the previous one.
module indexed_min_heap_queue #(
	parameter int MAX_ENTRIES = 64,
	localparam int IdW   = $clog2(MAX_ENTRIES + 1),
	localparam int InW   = ((imhq_pkg::REQ_W + IdW + imhq_pkg::SCORE_W + 7) / 8) * 8,
	localparam int OutW  = ((imhq_pkg::STAT_W + 2 * IdW + imhq_pkg::SCORE_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// req_type, entry_id, amount
	input  logic [InW-1:0]             s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status, result_id, result_score, heap_location
	output logic [OutW-1:0]            m_tdata,
	input  logic                       cfg_we,
	input  logic [imhq_pkg::CFG_W-1:0] cfg_wdata
);
	import imhq_pkg::*;

	localparam int SlotW = $clog2(MAX_ENTRIES);

	typedef struct packed {
		logic [IdW-1:0]            id;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	// memories
	entry_t         heap_mem [MAX_ENTRIES];
	logic [IdW-1:0] loc_mem  [MAX_ENTRIES + 1];

	entry_t         rd_a, rd_b;
	logic [SlotW-1:0] ra_addr, rb_addr;
	logic           hw_en;
	logic [SlotW-1:0] hw_addr;
	entry_t         hw_data;
	logic [IdW-1:0] loc_rd;
	logic [IdW-1:0] lr_addr;
	logic           lw_en;
	logic [IdW-1:0] lw_addr, lw_data;

	always_ff @(posedge clk) begin
		if (hw_en) begin
			heap_mem[hw_addr] <= hw_data;
		end
		rd_a <= heap_mem[ra_addr];
		rd_b <= heap_mem[rb_addr];
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			loc_mem[lw_addr] <= lw_data;
		end
		loc_rd <= loc_mem[lr_addr];
	end

	// registers
	imhq_state_t state_q, state_d;
	logic [CFG_W-1:0] cap_q;
	logic [REQ_W-1:0] req_q, req_d;
	logic [IdW-1:0] id_q, id_d;
	logic signed [SCORE_W-1:0] amt_q, amt_d;
	logic [IdW-1:0] loc_q, loc_d;
	logic [IdW-1:0] cnt_q, cnt_d;
	logic [SlotW-1:0] i_q, i_d;
	logic [IdW-1:0] mid_q, mid_d;
	logic signed [SCORE_W-1:0] msc_q, msc_d;
	logic [STAT_W-1:0] rst_q, rst_d;
	logic [IdW-1:0] rid_q, rid_d;
	logic signed [SCORE_W-1:0] rsc_q, rsc_d;
	logic [IdW-1:0] rloc_q, rloc_d;
	logic [IdW-1:0] clr_q, clr_d;
	logic m_tvalid_q, m_tvalid_d;
	logic [OutW-1:0] m_tdata_q, m_tdata_d;

	logic signed [SCORE_W-1:0] adj_res;

	imhq_adjust u_adjust (
		.cur   (rd_a.score),
		.delta (amt_q),
		.sub   (req_q == REQ_LOWER),
		.res   (adj_res)
	);

	logic [31:0] cap32, eff32;
	logic        id_ok, present, full, in_xfer;
	logic [SlotW+1:0] l_w, r_w, cnt_w;
	logic        lok, rok, take_l, take_r;
	logic signed [SCORE_W-1:0] best_sc;
	logic [SlotW-1:0] parent;

	assign in_xfer = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		cap32 = 32'(cap_q);
		if (cap32 == 32'd0) begin
			eff32 = 32'd1;
		end else if (cap32 > 32'(MAX_ENTRIES)) begin
			eff32 = 32'(MAX_ENTRIES);
		end else begin
			eff32 = cap32;
		end
		id_ok   = (id_q != '0) && (32'(id_q) <= eff32);
		present = id_ok && (loc_rd != '0) && (loc_rd <= cnt_q);
		full    = 32'(cnt_q) >= eff32;
		l_w     = {1'b0, i_q, 1'b1};
		r_w     = l_w + 1'b1;
		cnt_w   = (SlotW + 2)'(cnt_q);
		lok     = l_w < cnt_w;
		rok     = r_w < cnt_w;
		take_l  = lok && (rd_a.score < msc_q);
		best_sc = take_l ? rd_a.score : msc_q;
		take_r  = rok && (rd_b.score < best_sc);
		parent  = (i_q - 1'b1) >> 1;
	end

	always_comb begin
		state_d = state_q;
		req_d = req_q; id_d = id_q; amt_d = amt_q; loc_d = loc_q;
		cnt_d = cnt_q; i_d = i_q; mid_d = mid_q; msc_d = msc_q;
		rst_d = rst_q; rid_d = rid_q; rsc_d = rsc_q; rloc_d = rloc_q;
		clr_d = clr_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		m_tdata_d = m_tdata_q;
		ra_addr = '0; rb_addr = '0;
		hw_en = 1'b0; hw_addr = i_q; hw_data = '{id: mid_q, score: msc_q};
		lr_addr = id_q;
		lw_en = 1'b0; lw_addr = mid_q; lw_data = IdW'({1'b0, i_q} + 1'b1);

		unique case (state_q)
			S_CLR: begin
				lw_en = 1'b1;
				lw_addr = clr_q;
				lw_data = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == IdW'(MAX_ENTRIES)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				lr_addr = s_tdata[REQ_W +: IdW];
				if (in_xfer) begin
					req_d = s_tdata[REQ_W-1:0];
					id_d  = s_tdata[REQ_W +: IdW];
					amt_d = s_tdata[REQ_W + IdW +: SCORE_W];
					state_d = S_LOC;
				end
			end
			S_LOC: begin
				loc_d = loc_rd;
				ra_addr = SlotW'(loc_rd - 1'b1);
				rst_d = ST_OK; rid_d = id_q; rsc_d = '0; rloc_d = '0;
				state_d = S_DONE;
				case (req_q)
					REQ_INSERT: begin
						if (!id_ok) begin
							rst_d = ST_ABSENT;
						end else if (present) begin
							state_d = S_RDRES;
						end else if (full) begin
							rst_d = ST_FULL;
						end else begin
							mid_d = id_q;
							msc_d = amt_q;
							i_d = SlotW'(cnt_q);
							cnt_d = cnt_q + 1'b1;
							state_d = S_SU_RD;
						end
					end
					REQ_FIND, REQ_LOCATE: begin
						if (!present) rst_d = ST_ABSENT;
						else state_d = S_RDRES;
					end
					REQ_RAISE, REQ_LOWER: begin
						if (!present) rst_d = ST_ABSENT;
						else state_d = S_ADJ;
					end
					REQ_POP, REQ_CROWN: begin
						if (cnt_q == '0) begin
							rst_d = ST_EMPTY;
							rid_d = '0;
						end else begin
							state_d = S_PRD;
						end
					end
					default: ;
				endcase
			end
			S_RDRES: begin
				rst_d = (req_q == REQ_INSERT) ? ST_DUP : ST_OK;
				rsc_d = rd_a.score;
				rloc_d = loc_q;
				state_d = S_DONE;
			end
			S_ADJ: begin
				mid_d = id_q;
				msc_d = adj_res;
				i_d = SlotW'(loc_q - 1'b1);
				state_d = S_SU_RD;
			end
			S_PRD: begin
				ra_addr = '0;
				rb_addr = SlotW'(cnt_q - 1'b1);
				state_d = S_POP;
			end
			S_POP: begin
				rst_d = ST_OK;
				rid_d = rd_a.id;
				rsc_d = rd_a.score;
				if (req_q == REQ_CROWN && cnt_q == IdW'(1)) begin
					rloc_d = IdW'(1);
					state_d = S_DONE;
				end else begin
					rloc_d = '0;
					// the popped id loses its handle
					lw_en = 1'b1;
					lw_addr = rd_a.id;
					lw_data = '0;
					cnt_d = cnt_q - 1'b1;
					if (cnt_q == IdW'(1)) begin
						state_d = S_DONE;
					end else begin
						mid_d = rd_b.id;
						msc_d = rd_b.score;
						i_d = '0;
						state_d = S_SD_RD;
					end
				end
			end
			S_SU_RD: begin
				ra_addr = parent;
				state_d = (i_q == '0) ? S_SD_RD : S_SU_CMP;
			end
			S_SU_CMP: begin
				if (rd_a.score <= msc_q) begin
					state_d = S_SD_RD;
				end else begin
					// parent moves down into the hole
					hw_en = 1'b1;
					hw_data = rd_a;
					lw_en = 1'b1;
					lw_addr = rd_a.id;
					i_d = parent;
					state_d = S_SU_RD;
				end
			end
			S_SD_RD: begin
				ra_addr = l_w[SlotW-1:0];
				rb_addr = r_w[SlotW-1:0];
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				hw_en = 1'b1;
				lw_en = 1'b1;
				if (take_r || take_l) begin
					hw_data = take_r ? rd_b : rd_a;
					lw_addr = take_r ? rd_b.id : rd_a.id;
					i_d = take_r ? r_w[SlotW-1:0] : l_w[SlotW-1:0];
					state_d = S_SD_RD;
				end else begin
					// moving entry settles here
					case (req_q)
						REQ_POP: state_d = S_DONE;
						REQ_CROWN: state_d = S_PRD;
						default: begin
							rst_d = ST_OK;
							rid_d = id_q;
							rsc_d = msc_q;
							rloc_d = IdW'({1'b0, i_q} + 1'b1);
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_tdata_d = OutW'({rloc_q, rsc_q, rid_q, rst_q});
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cap_q <= CFG_W'(64);
			cnt_q <= '0;
			clr_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			cnt_q <= cnt_d;
			clr_q <= clr_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d; id_q <= id_d; amt_q <= amt_d; loc_q <= loc_d;
		i_q <= i_d; mid_q <= mid_d; msc_q <= msc_d;
		rst_q <= rst_d; rid_q <= rid_d; rsc_q <= rsc_d; rloc_q <= rloc_d;
		m_tdata_q <= m_tdata_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(MAX_ENTRIES)) else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 ||
		cnt_q == $past(cnt_q) - 1'b1)) else $error("entry count jumped");

	a_accept_loc: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_LOC) else $error("accepted request not looked up");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!m_tvalid_q || m_tready)) |=> m_tvalid_q)
		else $error("finished result not presented");

endmodule

// ===== verif/indexed_min_heap_queue_test.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_queue_test;
	import imhq_pkg::*;

	localparam int MAX_ENTRIES = 64;
	localparam int IdW = 7;
	localparam int InW = 48;
	localparam int OutW = 56;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IdW-1:0] rid;
		logic signed [SCORE_W-1:0] score;
		logic [IdW-1:0] loc;
	} heap_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [InW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OutW-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	indexed_min_heap_queue #(.MAX_ENTRIES(MAX_ENTRIES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// heap shadow
	int unsigned cap_reg;
	int unsigned heap_size;
	logic [IdW-1:0] heap_id [MAX_ENTRIES];
	logic signed [SCORE_W-1:0] heap_score [MAX_ENTRIES];
	int unsigned slot_of [MAX_ENTRIES + 1];

	heap_result_t pending_results [$];
	int errors;
	longint cycles;
	bit long_hold;
	int burst_left;

	function automatic void place(int unsigned s, logic [IdW-1:0] id, logic signed [31:0] sc);
		heap_id[s] = id;
		heap_score[s] = sc;
		if (id <= MAX_ENTRIES) slot_of[id] = s + 1;
	endfunction

	function automatic void swap_pair(int unsigned a, int unsigned b);
		logic [IdW-1:0] ia;
		logic signed [31:0] sa;
		ia = heap_id[a];
		sa = heap_score[a];
		place(a, heap_id[b], heap_score[b]);
		place(b, ia, sa);
	endfunction

	function automatic int unsigned bubble_up(int unsigned i);
		int unsigned p;
		while (i != 0) begin
			p = (i - 1) / 2;
			if (heap_score[p] <= heap_score[i]) break;
			swap_pair(i, p);
			i = p;
		end
		return i;
	endfunction

	function automatic int unsigned bubble_down(int unsigned i);
		int unsigned m;
		forever begin
			m = i;
			if (2*i+1 < heap_size && heap_score[2*i+1] < heap_score[m]) m = 2*i+1;
			if (2*i+2 < heap_size && heap_score[2*i+2] < heap_score[m]) m = 2*i+2;
			if (m == i) return i;
			swap_pair(i, m);
			i = m;
		end
	endfunction

	function automatic void drop_root();
		logic [IdW-1:0] gone;
		gone = heap_id[0];
		heap_size--;
		if (heap_size > 0) begin
			place(0, heap_id[heap_size], heap_score[heap_size]);
			void'(bubble_down(0));
		end
		if (gone <= MAX_ENTRIES) slot_of[gone] = 0;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic heap_result_t predict_request(logic [2:0] req, logic [IdW-1:0] id,
			logic signed [31:0] amt);
		heap_result_t r;
		int unsigned c, lc, s;
		bit ok_id, here;
		longint v;
		c = (cap_reg < 1) ? 1 : (cap_reg > MAX_ENTRIES ? MAX_ENTRIES : cap_reg);
		ok_id = id >= 1 && id <= c;
		lc = ok_id ? slot_of[id] : 0;
		here = ok_id && lc != 0 && lc <= heap_size;
		r = '{status: ST_OK, rid: id, score: '0, loc: '0};
		case (req)
			REQ_INSERT: begin
				if (!ok_id) r.status = ST_ABSENT;
				else if (here) begin
					r.status = ST_DUP;
					r.score = heap_score[lc-1];
					r.loc = IdW'(lc);
				end else if (heap_size >= c) r.status = ST_FULL;
				else begin
					place(heap_size, id, amt);
					heap_size++;
					s = bubble_up(heap_size - 1);
					r.score = heap_score[s];
					r.loc = IdW'(s + 1);
				end
			end
			REQ_FIND, REQ_LOCATE: begin
				if (!here) r.status = ST_ABSENT;
				else begin
					r.score = heap_score[lc-1];
					r.loc = IdW'(lc);
				end
			end
			REQ_POP: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
					r.rid = 0;
				end else begin
					r.rid = heap_id[0];
					r.score = heap_score[0];
					drop_root();
				end
			end
			REQ_RAISE, REQ_LOWER: begin
				if (!here) r.status = ST_ABSENT;
				else begin
					s = lc - 1;
					v = (req == REQ_RAISE) ? longint'(heap_score[s]) + longint'(amt)
						: longint'(heap_score[s]) - longint'(amt);
					heap_score[s] = clamp32(v);
					s = bubble_up(s);
					s = bubble_down(s);
					r.score = heap_score[s];
					r.loc = IdW'(s + 1);
				end
			end
			REQ_CROWN: begin
				if (heap_size == 0) begin
					r.status = ST_EMPTY;
					r.rid = 0;
				end else begin
					while (heap_size > 1) drop_root();
					r.rid = heap_id[0];
					r.score = heap_score[0];
					r.loc = 1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// sender: bursts with random gaps
	task automatic send_request(logic [2:0] req, logic [IdW-1:0] id, logic [31:0] amt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tdata <= {6'b0, amt, id, req};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_request(req, id, amt));
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
	endtask

	task automatic write_capacity(int unsigned v);
		go_idle();
		cfg_wdata <= CFG_W'(v);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	function automatic logic [31:0] rand_score();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IdW-1:0] rand_id();
		int unsigned c;
		c = (cap_reg < 1) ? 1 : (cap_reg > MAX_ENTRIES ? MAX_ENTRIES : cap_reg);
		if ($urandom_range(0, 15) == 0) return IdW'($urandom);
		return IdW'($urandom_range(1, c));
	endfunction

	task automatic test_directed();
		send_request(REQ_POP, 1, 0);
		send_request(REQ_CROWN, 1, 0);
		send_request(REQ_FIND, 5, 0);
		send_request(REQ_INSERT, 0, 5);
		send_request(REQ_INSERT, 127, 5);
		send_request(REQ_INSERT, 3, 32'h7fffffff);
		send_request(REQ_INSERT, 64, 32'h80000000);
		send_request(REQ_INSERT, 3, 9);
		send_request(REQ_INSERT, 10, 0);
		send_request(REQ_INSERT, 11, 0);
		send_request(REQ_RAISE, 3, 32'h7fffffff);
		send_request(REQ_LOWER, 64, 32'h7fffffff);
		send_request(REQ_RAISE, 10, 32'h80000000);
		send_request(REQ_LOWER, 11, 32'h80000000);
		send_request(REQ_LOCATE, 11, 0);
		send_request(REQ_LOCATE, 12, 0);
		send_request(3'd7, 10, 32'hffffffff);
		send_request(REQ_POP, 0, 0);
		send_request(REQ_CROWN, 0, 0);
		send_request(REQ_FIND, 64, 0);
		send_request(REQ_POP, 0, 0);
	endtask

	task automatic test_full_and_capacity();
		write_capacity(2);
		for (int i = 1; i <= 4; i++) send_request(REQ_INSERT, IdW'(i), rand_score());
		write_capacity(1);
		send_request(REQ_FIND, 2, 0);
		send_request(REQ_POP, 0, 0);
		send_request(REQ_POP, 0, 0);
		write_capacity(0);
		send_request(REQ_INSERT, 1, 4);
		send_request(REQ_INSERT, 2, 4);
		write_capacity(127);
		send_request(REQ_INSERT, 64, 4);
		send_request(REQ_INSERT, 65, 4);
	endtask

	task automatic test_random(int n, int unsigned capv);
		logic [2:0] req;
		write_capacity(capv);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: req = REQ_INSERT;
				6, 7: req = REQ_FIND;
				8, 9, 10: req = REQ_POP;
				11, 12: req = REQ_RAISE;
				13, 14: req = REQ_LOWER;
				15, 16: req = REQ_LOCATE;
				17: req = ($urandom_range(0, 3) == 0) ? REQ_CROWN : REQ_FIND;
				default: req = 3'($urandom_range(0, 7));
			endcase
			send_request(req, rand_id(), rand_score());
		end
	endtask

	task automatic test_backpressure();
		long_hold = 1'b1;
		for (int k = 0; k < 40; k++) send_request(REQ_INSERT, rand_id(), rand_score());
		long_hold = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		heap_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tdata[2:0], rid: m_tdata[9:3], score: m_tdata[41:10],
				loc: m_tdata[48:42]};
			if (pending_results.size() == 0) report_mismatch("unexpected transfer", 1, 0);
			else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) report_mismatch("status", got.status, want.status);
				if (got.rid !== want.rid) report_mismatch("result_id", got.rid, want.rid);
				if (got.score !== want.score) report_mismatch("result_score", got.score, want.score);
				if (got.loc !== want.loc) report_mismatch("heap_location", got.loc, want.loc);
			end
		end
	end

	// receiver stall pattern, with a long hold-off when asked
	always @(negedge clk) begin
		int unsigned hold;
		if (long_hold) begin
			m_tready <= 1'b0;
			for (hold = 0; hold < 600; hold++) @(negedge clk);
			m_tready <= 1'b1;
			wait (!long_hold);
		end else m_tready <= (cycles % 200 < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		long_hold = 1'b0;
		burst_left = 0;
		cap_reg = 64;
		heap_size = 0;
		for (int i = 0; i <= MAX_ENTRIES; i++) slot_of[i] = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_and_capacity();
		test_random(700, 64);
		test_backpressure();
		test_random(300, 8);
		test_random(400, 64);
		test_random(300, 33);
		test_random(150, 1);
		go_idle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
